/* hdl/vrc_pkg.sv */
// Shared types, constants and lookup tables for the visibility ray caster.
package vrc_pkg;

  localparam int COORD_W      = 24;
  localparam int ANGLE_W      = 16;
  localparam int SEG_DEPTH    = 64;
  localparam int SLOT_W       = $clog2(SEG_DEPTH);
  localparam int USE_W        = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int CW           = 44;            // CORDIC x/y datapath
  localparam int ZW           = 34;            // CORDIC angle accumulator
  localparam int DIFF_W       = COORD_W + 1;   // coordinate differences
  localparam int Q14_W        = 16;            // ray components, Q1.14
  localparam int MULB_W       = 18;
  localparam int PROD_W       = DIFF_W + MULB_W;
  localparam int ACC_W        = PROD_W + 1;
  localparam int IX_W         = COORD_W + 2;   // intersection point
  localparam int DIST_W       = IX_W + 1;
  localparam int T1_SHIFT     = 14;
  localparam int QW           = DIST_W + T1_SHIFT;
  localparam int T2_W         = 17;
  localparam int T2_BITS      = 16;
  localparam int DCNT_W       = 6;

  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic signed [CW-1:0] NORM_LIM  = CW'(64'h40_0000_0000);
  localparam logic signed [CW-1:0] ROT_X0    = CW'(64'd652032874);
  localparam logic signed [CW-1:0] Q14_ONE   = CW'(64'd16384);
  localparam logic signed [CW-1:0] Q14_RND   = CW'(64'd32768);
  localparam logic [31:0]          ANG_HALF  = 32'(64'd1 << (31 - ANGLE_W));
  localparam logic [31:0]          ANG_PI    = 32'h8000_0000;
  localparam logic [31:0]          ANG_QTR   = 32'h4000_0000;
  localparam logic [T2_W-1:0]      T2_ONE    = T2_W'(64'd65536);

  typedef struct packed {
    logic                      action;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      which_end;
    logic [USE_W-1:0]          segments_in_use;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic [ANGLE_W-1:0]        hit_angle;
    logic [1:0]                ray_number;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } seg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TGT, S_NORM, S_VEC, S_BASE, S_ROT_INIT, S_ROT, S_SC,
    S_SEG_RD, S_SEG_LD, S_M0, S_M1, S_M2, S_M3, S_CHK, S_DIV_T2,
    S_M4, S_M5, S_R5, S_T1_SET, S_DIV_T1, S_UPD, S_EMIT
  } state_t;

  // arctan(2^-i) in 32-bit binary angle units
  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;  5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* hdl/visibility_ray_caster_unit.sv */
// Visibility ray caster: segment store, CORDIC unit, intersection sequencer.
//
// A write beat stores one wall segment in its slot. A cast beat aims from the
// viewer at one end of a stored segment and at one angle unit either side, and
// returns three result beats (ray 0, 1, 2; last on ray 2) with the nearest hit
// among slots 0..segments_in_use-1. A segment rejected by the crossing test
// skips both divisions, and one rejected on the distance sign skips the ray
// distance division. The time of a cast is set by the shared CORDIC unit (30
// iterations per angle, plus one-bit-per-cycle normalization before atan2), by
// the single shared multiplier (up to six products per segment) and by the shared
// restoring divider that retires one quotient bit per cycle (16 bits for the
// segment parameter, 41 bits for the ray distance). Segments live in one 64 x
// 96 synchronous RAM with a registered read; writes happen only while idle, so
// no read can meet a pending write to the same slot. Unwritten slots read as
// whatever the RAM holds. The input is taken only while idle; a finished result
// waits in the output register without holding off the next input beat.
module visibility_ray_caster_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vrc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vrc_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [vrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vrc_pkg::COORD_W-1:0]     cfg_data
);

  localparam int CW     = vrc_pkg::CW;
  localparam int ZW     = vrc_pkg::ZW;
  localparam int DIFF_W = vrc_pkg::DIFF_W;
  localparam int ACC_W  = vrc_pkg::ACC_W;
  localparam int IX_W   = vrc_pkg::IX_W;
  localparam int DIST_W = vrc_pkg::DIST_W;
  localparam int QW     = vrc_pkg::QW;
  localparam int Q14_W  = vrc_pkg::Q14_W;
  localparam int COORD_W = vrc_pkg::COORD_W;

  // Widen a coordinate by one bit, keeping its sign.
  function automatic logic signed [DIFF_W-1:0] ext_c(input logic signed [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  // Round a CORDIC output to Q1.14 and clamp to +-1.0.
  function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + vrc_pkg::Q14_RND) >>> 16;
    if (t > vrc_pkg::Q14_ONE)       t = vrc_pkg::Q14_ONE;
    else if (t < -vrc_pkg::Q14_ONE) t = -vrc_pkg::Q14_ONE;
    return t[Q14_W-1:0];
  endfunction

  // Drop 16 fraction bits, rounding half away from zero.
  function automatic logic signed [IX_W-1:0] round_q16(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] r;
    m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r = (m + ACC_W'(32768)) >> 16;
    return v[ACC_W-1] ? IX_W'(-r) : IX_W'(r);
  endfunction

  // Round a 32-bit binary angle to the output angle width.
  function automatic logic [vrc_pkg::ANGLE_W-1:0] zsum_base(input logic [31:0] z);
    logic [31:0] s;
    s = z + vrc_pkg::ANG_HALF;
    return s[31 -: vrc_pkg::ANGLE_W];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  vrc_pkg::state_t                state_r, state_nxt;

  logic signed [COORD_W-1:0]      vx_r, vy_r;

  vrc_pkg::seg_t                  seg_mem [vrc_pkg::SEG_DEPTH];
  vrc_pkg::seg_t                  rd_data_r;
  logic                           mem_we, mem_re;
  logic [vrc_pkg::SLOT_W-1:0]     mem_raddr;

  logic                           which_end_r;
  logic [vrc_pkg::USE_W-1:0]      n_r, j_r;

  logic signed [CW-1:0]           cx_r, cy_r;
  logic signed [ZW-1:0]           cz_r;
  logic [vrc_pkg::STEP_W-1:0]     cnt_r;

  logic [vrc_pkg::ANGLE_W-1:0]    base_r, ang_r;
  logic                           flip_r;
  logic [1:0]                     k_r;
  logic signed [Q14_W-1:0]        rx_r, ry_r;

  logic signed [DIFF_W-1:0]       ddx_r, ddy_r, ax_r, ay_r;
  logic signed [ACC_W-1:0]        den_r, num_r, p_r;
  logic signed [IX_W-1:0]         ix_r, iy_r;

  logic [ACC_W-1:0]               rem_r, dsor_r;
  logic [QW-1:0]                  dnum_r, quo_r;
  logic [vrc_pkg::DCNT_W-1:0]     dcnt_r;

  logic                           found_r;
  logic [QW-1:0]                  bt_r;
  logic signed [COORD_W-1:0]      bx_r, by_r;

  logic                           out_valid_r;
  vrc_pkg::out_item_t             out_data_r;

  // ---------------------------------------------------------------------------
  // Datapath decode
  // ---------------------------------------------------------------------------
  logic                           accept, out_load, out_free;
  logic                           last_seg, seg_done;
  logic signed [DIFF_W-1:0]       tdx, tdy;
  logic                           tgt_zero, norm_small, cordic_last, div_last;

  logic signed [CW-1:0]           xs, ys, cx_n, cy_n;
  logic signed [ZW-1:0]           cz_n, at_z;
  logic                           pos;

  logic [vrc_pkg::ANGLE_W-1:0]    ang_c;
  logic [31:0]                    a32, a_rot, zsum;
  logic                           flip_c;

  logic signed [DIFF_W-1:0]       mul_a;
  logic signed [vrc_pkg::MULB_W-1:0] mul_b;
  logic signed [vrc_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]        prod_x;

  logic [ACC_W-1:0]               an, ad;
  logic                           chk_skip, chk_eq;

  logic [ACC_W-1:0]               rem_sh, rem_n;
  logic                           div_ge;

  logic                           sel_x;
  logic signed [Q14_W-1:0]        comp_c;
  logic [Q14_W-1:0]               arx, ary, acomp;
  logic signed [DIST_W-1:0]       dist_c;
  logic [DIST_W-1:0]              adist;
  logic                           t1_skip, upd_take;

  assign in_ready  = (state_r == vrc_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    // target vector from the viewer
    tdx = which_end_r ? ext_c(rd_data_r.ex) - ext_c(vx_r) : ext_c(rd_data_r.sx) - ext_c(vx_r);
    tdy = which_end_r ? ext_c(rd_data_r.ey) - ext_c(vy_r) : ext_c(rd_data_r.sy) - ext_c(vy_r);
    tgt_zero = (tdx == '0) && (tdy == '0);

    norm_small = (cx_r < vrc_pkg::NORM_LIM) && (cx_r > -vrc_pkg::NORM_LIM) &&
                 (cy_r < vrc_pkg::NORM_LIM) && (cy_r > -vrc_pkg::NORM_LIM);
    cordic_last = (cnt_r == vrc_pkg::STEP_W'(vrc_pkg::CORDIC_STEPS - 1));
    div_last    = (dcnt_r == vrc_pkg::DCNT_W'(1));
    last_seg    = ((j_r + vrc_pkg::USE_W'(1)) == n_r);

    // one CORDIC micro-rotation; vectoring drives y toward zero
    xs   = cx_r >>> cnt_r;
    ys   = cy_r >>> cnt_r;
    at_z = ZW'(vrc_pkg::atan_entry(cnt_r));
    pos  = (state_r == vrc_pkg::S_ROT) ? !cz_r[ZW-1] : (cy_r <= 0);
    cx_n = pos ? cx_r - ys : cx_r + ys;
    cy_n = pos ? cy_r + xs : cy_r - xs;
    cz_n = pos ? cz_r - at_z : cz_r + at_z;

    // ray angle and quadrant fold for rotation
    ang_c  = base_r + vrc_pkg::ANGLE_W'(k_r) - vrc_pkg::ANGLE_W'(1);
    a32    = {ang_c, {(32 - vrc_pkg::ANGLE_W){1'b0}}};
    zsum   = a32 + vrc_pkg::ANG_QTR;
    flip_c = zsum[31];
    a_rot  = flip_c ? a32 ^ vrc_pkg::ANG_PI : a32;

    // segment test
    an = num_r[ACC_W-1] ? ACC_W'(-num_r) : ACC_W'(num_r);
    ad = den_r[ACC_W-1] ? ACC_W'(-den_r) : ACC_W'(den_r);
    chk_skip = (den_r == '0) ||
               ((num_r != '0) && (num_r[ACC_W-1] != den_r[ACC_W-1])) ||
               (an > ad);
    chk_eq = (an == ad);

    // restoring divider, one quotient bit per cycle
    rem_sh = {rem_r[ACC_W-2:0], dnum_r[QW-1]};
    div_ge = (rem_sh >= dsor_r);
    rem_n  = div_ge ? rem_sh - dsor_r : rem_sh;

    // distance along the larger ray component, x on a tie
    arx    = rx_r[Q14_W-1] ? Q14_W'(-rx_r) : Q14_W'(rx_r);
    ary    = ry_r[Q14_W-1] ? Q14_W'(-ry_r) : Q14_W'(ry_r);
    sel_x  = (arx >= ary);
    comp_c = sel_x ? rx_r : ry_r;
    acomp  = sel_x ? arx : ary;
    dist_c = sel_x ? DIST_W'(ix_r) - DIST_W'(vx_r) : DIST_W'(iy_r) - DIST_W'(vy_r);
    adist  = dist_c[DIST_W-1] ? DIST_W'(-dist_c) : DIST_W'(dist_c);
    t1_skip = (comp_c == '0) || (dist_c == '0) ||
              (dist_c[DIST_W-1] != comp_c[Q14_W-1]);

    upd_take = (quo_r != '0) && (!found_r || (quo_r < bt_r));
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vrc_pkg::S_IDLE:     if (accept && (in_data.action == vrc_pkg::ACT_CAST)) begin
                             state_nxt = vrc_pkg::S_TGT;
                           end
      vrc_pkg::S_TGT:      state_nxt = tgt_zero ? vrc_pkg::S_BASE : vrc_pkg::S_NORM;
      vrc_pkg::S_NORM:     if (!norm_small) state_nxt = vrc_pkg::S_VEC;
      vrc_pkg::S_VEC:      if (cordic_last) state_nxt = vrc_pkg::S_BASE;
      vrc_pkg::S_BASE:     state_nxt = vrc_pkg::S_ROT_INIT;
      vrc_pkg::S_ROT_INIT: state_nxt = vrc_pkg::S_ROT;
      vrc_pkg::S_ROT:      if (cordic_last) state_nxt = vrc_pkg::S_SC;
      vrc_pkg::S_SC:       state_nxt = (n_r == '0) ? vrc_pkg::S_EMIT : vrc_pkg::S_SEG_RD;
      vrc_pkg::S_SEG_RD:   state_nxt = vrc_pkg::S_SEG_LD;
      vrc_pkg::S_SEG_LD:   state_nxt = vrc_pkg::S_M0;
      vrc_pkg::S_M0:       state_nxt = vrc_pkg::S_M1;
      vrc_pkg::S_M1:       state_nxt = vrc_pkg::S_M2;
      vrc_pkg::S_M2:       state_nxt = vrc_pkg::S_M3;
      vrc_pkg::S_M3:       state_nxt = vrc_pkg::S_CHK;
      vrc_pkg::S_CHK: begin
        if (chk_skip)    state_nxt = last_seg ? vrc_pkg::S_EMIT : vrc_pkg::S_SEG_RD;
        else if (chk_eq) state_nxt = vrc_pkg::S_M4;
        else             state_nxt = vrc_pkg::S_DIV_T2;
      end
      vrc_pkg::S_DIV_T2:   if (div_last) state_nxt = vrc_pkg::S_M4;
      vrc_pkg::S_M4:       state_nxt = vrc_pkg::S_M5;
      vrc_pkg::S_M5:       state_nxt = vrc_pkg::S_R5;
      vrc_pkg::S_R5:       state_nxt = vrc_pkg::S_T1_SET;
      vrc_pkg::S_T1_SET: begin
        if (t1_skip) state_nxt = last_seg ? vrc_pkg::S_EMIT : vrc_pkg::S_SEG_RD;
        else         state_nxt = vrc_pkg::S_DIV_T1;
      end
      vrc_pkg::S_DIV_T1:   if (div_last) state_nxt = vrc_pkg::S_UPD;
      vrc_pkg::S_UPD:      state_nxt = last_seg ? vrc_pkg::S_EMIT : vrc_pkg::S_SEG_RD;
      vrc_pkg::S_EMIT: begin
        if (out_free) state_nxt = (k_r == 2'd2) ? vrc_pkg::S_IDLE : vrc_pkg::S_ROT_INIT;
      end
      default:             state_nxt = vrc_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs: RAM port, multiplier operands, segment and result strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = j_r[vrc_pkg::SLOT_W-1:0];
    mul_a     = ddx_r;
    mul_b     = {{(vrc_pkg::MULB_W - Q14_W){ry_r[Q14_W-1]}}, ry_r};
    seg_done  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      vrc_pkg::S_IDLE: begin
        mem_we    = accept && (in_data.action == vrc_pkg::ACT_WRITE);
        mem_re    = accept && (in_data.action == vrc_pkg::ACT_CAST);
        mem_raddr = in_data.slot;
      end
      vrc_pkg::S_SEG_RD: mem_re = 1'b1;
      vrc_pkg::S_M1: begin
        mul_a = ddy_r;
        mul_b = {{(vrc_pkg::MULB_W - Q14_W){rx_r[Q14_W-1]}}, rx_r};
      end
      vrc_pkg::S_M2: begin
        mul_a = ay_r;
        mul_b = {{(vrc_pkg::MULB_W - Q14_W){rx_r[Q14_W-1]}}, rx_r};
      end
      vrc_pkg::S_M3:   mul_a = ax_r;
      vrc_pkg::S_M4:   mul_b = {1'b0, quo_r[vrc_pkg::T2_W-1:0]};
      vrc_pkg::S_M5: begin
        mul_a = ddy_r;
        mul_b = {1'b0, quo_r[vrc_pkg::T2_W-1:0]};
      end
      vrc_pkg::S_CHK:    seg_done = chk_skip;
      vrc_pkg::S_T1_SET: seg_done = t1_skip;
      vrc_pkg::S_UPD:    seg_done = 1'b1;
      vrc_pkg::S_EMIT:   out_load = out_free;
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_x = ACC_W'(prod);

  // ---------------------------------------------------------------------------
  // Segment RAM: one write port, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_mem[in_data.slot] <= '{sx: in_data.start_x, sy: in_data.start_y,
                                 ex: in_data.end_x,   ey: in_data.end_y};
    end
    if (mem_re) begin
      rd_data_r <= seg_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vrc_pkg::S_IDLE;
      vx_r        <= '0;
      vy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          vrc_pkg::REG_VIEWER_X: vx_r <= cfg_data;
          vrc_pkg::REG_VIEWER_Y: vy_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (seg_done) j_r <= j_r + vrc_pkg::USE_W'(1);
    case (state_r)
      vrc_pkg::S_IDLE: begin
        which_end_r <= in_data.which_end;
        n_r <= (in_data.segments_in_use > vrc_pkg::USE_W'(vrc_pkg::SEG_DEPTH)) ?
               vrc_pkg::USE_W'(vrc_pkg::SEG_DEPTH) : in_data.segments_in_use;
      end
      vrc_pkg::S_TGT: begin
        cnt_r <= '0;
        if (tgt_zero) begin
          cz_r <= '0;
        end else if (tdx[DIFF_W-1]) begin
          // fold into the right half plane, remember half a turn
          cx_r <= -CW'(tdx);
          cy_r <= -CW'(tdy);
          cz_r <= ZW'(vrc_pkg::ANG_PI);
        end else begin
          cx_r <= CW'(tdx);
          cy_r <= CW'(tdy);
          cz_r <= '0;
        end
      end
      vrc_pkg::S_NORM: begin
        if (norm_small) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
      end
      vrc_pkg::S_VEC, vrc_pkg::S_ROT: begin
        cx_r  <= cx_n;
        cy_r  <= cy_n;
        cz_r  <= cz_n;
        cnt_r <= cnt_r + vrc_pkg::STEP_W'(1);
      end
      vrc_pkg::S_BASE: begin
        base_r <= zsum_base(cz_r[31:0]);
        k_r    <= '0;
      end
      vrc_pkg::S_ROT_INIT: begin
        ang_r   <= ang_c;
        flip_r  <= flip_c;
        cx_r    <= vrc_pkg::ROT_X0;
        cy_r    <= '0;
        cz_r    <= {{(ZW - 32){a_rot[31]}}, a_rot};
        cnt_r   <= '0;
        found_r <= 1'b0;
        bx_r    <= '0;
        by_r    <= '0;
        j_r     <= '0;
      end
      vrc_pkg::S_SC: begin
        rx_r <= flip_r ? -to_q14(cx_r) : to_q14(cx_r);
        ry_r <= flip_r ? -to_q14(cy_r) : to_q14(cy_r);
      end
      vrc_pkg::S_SEG_LD: begin
        ddx_r <= ext_c(rd_data_r.ex) - ext_c(rd_data_r.sx);
        ddy_r <= ext_c(rd_data_r.ey) - ext_c(rd_data_r.sy);
        ay_r  <= ext_c(rd_data_r.sy) - ext_c(vy_r);
        ax_r  <= ext_c(vx_r) - ext_c(rd_data_r.sx);
      end
      vrc_pkg::S_M0: den_r <= prod_x;
      vrc_pkg::S_M1: den_r <= den_r - prod_x;
      vrc_pkg::S_M2: num_r <= prod_x;
      vrc_pkg::S_M3: num_r <= num_r + prod_x;
      vrc_pkg::S_CHK: begin
        rem_r  <= an;
        dsor_r <= ad;
        dnum_r <= '0;
        dcnt_r <= vrc_pkg::DCNT_W'(vrc_pkg::T2_BITS);
        quo_r  <= chk_eq ? QW'(vrc_pkg::T2_ONE) : '0;
      end
      vrc_pkg::S_DIV_T2, vrc_pkg::S_DIV_T1: begin
        rem_r  <= rem_n;
        quo_r  <= {quo_r[QW-2:0], div_ge};
        dnum_r <= {dnum_r[QW-2:0], 1'b0};
        dcnt_r <= dcnt_r - vrc_pkg::DCNT_W'(1);
      end
      vrc_pkg::S_M4: p_r <= prod_x;
      vrc_pkg::S_M5: begin
        p_r  <= prod_x;
        ix_r <= IX_W'(rd_data_r.sx) + round_q16(p_r);
      end
      vrc_pkg::S_R5: iy_r <= IX_W'(rd_data_r.sy) + round_q16(p_r);
      vrc_pkg::S_T1_SET: begin
        rem_r  <= '0;
        dsor_r <= ACC_W'(acomp);
        dnum_r <= {adist, {vrc_pkg::T1_SHIFT{1'b0}}};
        quo_r  <= '0;
        dcnt_r <= vrc_pkg::DCNT_W'(QW);
      end
      vrc_pkg::S_UPD: begin
        if (upd_take) begin
          found_r <= 1'b1;
          bt_r    <= quo_r;
          bx_r    <= ix_r[COORD_W-1:0];
          by_r    <= iy_r[COORD_W-1:0];
        end
      end
      vrc_pkg::S_EMIT: begin
        if (out_load) begin
          k_r <= k_r + 2'd1;
          out_data_r <= '{hit: found_r, hit_x: bx_r, hit_y: by_r, hit_angle: ang_r,
                          ray_number: k_r, last: (k_r == 2'd2)};
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // The segment loop never reads past the slots in use.
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vrc_pkg::S_SEG_RD) |-> (j_r < n_r))
    else $error("segment index beyond slots in use");

  // The divider never runs with an exhausted step count.
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vrc_pkg::S_DIV_T2 || state_r == vrc_pkg::S_DIV_T1) |-> (dcnt_r != '0))
    else $error("divider step count exhausted");

  // The segment parameter stays within [0, 1] in Q16.
  a_t2_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vrc_pkg::S_M4) |-> (quo_r <= QW'(vrc_pkg::T2_ONE)))
    else $error("segment parameter out of range");

  // A new result beat comes only from the emit step.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == vrc_pkg::S_EMIT))
    else $error("result beat raised outside emit");
`endif

endmodule
